[hdl/cmw_pkg.sv]
// Shared widths, codes, types and a helper function of the column melt wipe block.
package cmw_pkg;

	// Field and register widths.
	localparam int CMD_W      = 2;
	localparam int RAND_W     = 8;
	localparam int COL_W      = 9;
	localparam int ROW_W      = 12;
	localparam int TICK_W     = 4;
	localparam int HEIGHT_W   = 13;
	localparam int COUNT_W    = 10;
	localparam int SCALE_W    = 5;
	localparam int OFF_W      = 14;
	localparam int WALK_W     = 5;
	localparam int STEP_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_SEED  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

	// Register reset values.
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = 13'd200;
	localparam logic [COUNT_W-1:0]  COLUMNS_RESET = 10'd160;
	localparam logic [SCALE_W-1:0]  SCALE_RESET   = 5'd1;

	// Melt and walk constants.
	localparam int MELT_FAST_LIMIT = 16;
	localparam int MELT_STEP       = 8;
	localparam int WALK_FLOOR      = -16;
	localparam logic signed [WALK_W-1:0] WALK_MIN = -5'sd15;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_Q_EVAL,
		ST_T_READ,
		ST_T_WRITE,
		ST_RESP
	} state_t;

	// Results of the shared column unit.
	typedef struct packed {
		logic signed [OFF_W-1:0] new_off;
		logic                    active;
		logic                    from_end;
		logic [ROW_W-1:0]        source_row;
	} step_res_t;

	// Remainder of a byte by three; base-4 digits sum to the same remainder.
	function automatic logic [1:0] mod3_byte(input logic [RAND_W-1:0] v);
		logic [3:0] s;
		logic [2:0] t;
		logic [2:0] w;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		w = 3'(t[1:0]) + 3'(t[2]);
		return (w == 3'd3) ? 2'd0 : w[1:0];
	endfunction

endpackage

[hdl/cmw_if.sv]
// Valid/ready channels for command items and result items.
interface cmw_in_if import cmw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [RAND_W-1:0]   rand_value;
	logic [COL_W-1:0]    column;
	logic [ROW_W-1:0]    row;
	logic [TICK_W-1:0]   tick_count;

	modport source(output valid, cmd, rand_value, column, row, tick_count, input ready);
	modport sink(input valid, cmd, rand_value, column, row, tick_count, output ready);
endinterface

interface cmw_out_if import cmw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             done_res;
	logic             from_end;
	logic [ROW_W-1:0] source_row;

	modport source(output valid, done_res, from_end, source_row, input ready);
	modport sink(input valid, done_res, from_end, source_row, output ready);
endinterface

[hdl/cmw_offset_ram.sv]
// Column offset memory: one write port and one registered read port.
module cmw_offset_ram import cmw_pkg::*; #(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [ADDR_W-1:0]       waddr,
	input  logic signed [OFF_W-1:0] wdata,
	input  logic                    re,
	input  logic [ADDR_W-1:0]       raddr,
	output logic signed [OFF_W-1:0] rdata
);

	logic signed [OFF_W-1:0] mem_q [DEPTH];
	logic signed [OFF_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port: the data follows in the next cycle when re is set.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/cmw_step_unit.sv]
// Shared column unit: one melt step of an offset, or the pixel source for a query.
module cmw_step_unit import cmw_pkg::*; (
	input  logic signed [OFF_W-1:0] offset,
	input  logic [HEIGHT_W-1:0]     height,
	input  logic [SCALE_W-1:0]      scale,
	input  logic [ROW_W-1:0]        row,
	output step_res_t               res
);

	localparam int SUM_W = OFF_W + 1;
	localparam int DY_W  = STEP_W + SCALE_W;

	logic signed [OFF_W-1:0] height_s;
	logic [STEP_W-1:0]       base;
	logic [DY_W-1:0]         dy;
	logic [SUM_W-1:0]        sum;
	logic [HEIGHT_W-1:0]     depth;
	logic [HEIGHT_W-1:0]     diff;

	// Melt step and query share one block so that every result field has a single driver.
	always_comb begin
		// Melt step: delayed columns count up, moving columns fall, clamped at the height.
		height_s = signed'({1'b0, height});
		if (offset < MELT_FAST_LIMIT) begin
			base = STEP_W'(offset[STEP_W-2:0]) + STEP_W'(1);
		end else begin
			base = STEP_W'(MELT_STEP);
		end
		dy  = DY_W'(base) * DY_W'(scale);
		sum = SUM_W'(unsigned'(offset)) + SUM_W'(dy);
		res.new_off = offset;
		res.active  = 1'b0;
		if (offset < 0) begin
			res.new_off = offset + OFF_W'(1);
			res.active  = 1'b1;
		end else if (offset < height_s) begin
			res.active = 1'b1;
			if (sum >= SUM_W'(height)) begin
				res.new_off = height_s;
			end else begin
				res.new_off = signed'(sum[OFF_W-1:0]);
			end
		end

		// Query: rows above the offset come from the end screen.
		depth = (offset < 0) ? '0 : offset[HEIGHT_W-1:0];
		diff  = HEIGHT_W'(row) - depth;
		if (HEIGHT_W'(row) < depth) begin
			res.from_end   = 1'b1;
			res.source_row = row;
		end else begin
			res.from_end   = 1'b0;
			res.source_row = diff[ROW_W-1:0];
		end
	end

endmodule

[hdl/column_melt_wipe.sv]
// Column melt wipe: keeps one vertical offset per two-pixel column, seeds the offsets through a
// clamped random walk, advances them by melt ticks and answers pixel source queries. Every item
// gives exactly one result. The column offsets live in a single memory with one write and one
// registered read port, and one shared column unit does the melt and query arithmetic under a
// small sequencer, so one item is handled at a time: a seed goes straight to the result, a query
// passes through the memory read and the unit, and a tick reads each column and then writes it
// back updated, once per tick; a tick with no work goes straight to the result. A new item is
// taken while the previous result still waits in the output register. The offset memory is
// not cleared after reset; a column must be seeded before a tick or query reads it.
module column_melt_wipe import cmw_pkg::*; #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_HEIGHT  = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cmw_in_if.sink                item,
	cmw_out_if.source             result
);

	localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	// Configuration registers.
	logic [HEIGHT_W-1:0] screen_height_q;
	logic [COUNT_W-1:0]  column_count_q;
	logic [SCALE_W-1:0]  row_scale_q;

	// Sequencer and datapath registers.
	state_t                    state_q, state_d;
	logic [COUNT_W-1:0]        cnt_q;
	logic [TICK_W-1:0]         tick_left_q;
	logic signed [WALK_W-1:0]  walk_q;
	logic [ROW_W-1:0]          row_q;
	logic                      q_oor_q;
	logic                      res_done_q;
	logic                      res_from_end_q;
	logic [ROW_W-1:0]          res_src_q;
	logic                      out_valid_q;
	logic                      out_done_q;
	logic                      out_from_end_q;
	logic [ROW_W-1:0]          out_src_q;

	// Combinational signals.
	logic [HEIGHT_W-1:0]       height_eff;
	logic [COUNT_W-1:0]        n_eff;
	logic [SCALE_W-1:0]        scale_eff;
	logic                      in_ready;
	logic                      accept;
	logic                      col_in_range;
	logic                      last_col;
	logic                      slot_free;
	logic [ADDR_W-1:0]         col_addr;
	logic [ADDR_W-1:0]         cnt_addr;
	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic signed [OFF_W-1:0]   ram_wdata;
	logic                      ram_re;
	logic [ADDR_W-1:0]         ram_raddr;
	logic signed [OFF_W-1:0]   ram_rdata;
	logic signed [OFF_W-1:0]   unit_off;
	step_res_t                 step;
	logic [1:0]                rand_mod3;
	logic signed [WALK_W:0]    walk_sum;
	logic signed [WALK_W-1:0]  walk_new;
	logic signed [OFF_W-1:0]   seed_value;

	// Effective configuration values.
	always_comb begin
		height_eff = (32'(screen_height_q) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT) : screen_height_q;
		n_eff      = (32'(column_count_q) > MAX_COLUMNS) ? COUNT_W'(MAX_COLUMNS) : column_count_q;
		scale_eff  = (row_scale_q == '0) ? SCALE_W'(1) : row_scale_q;
	end

	assign accept       = item.valid && in_ready;
	assign col_in_range = 32'(item.column) < MAX_COLUMNS;
	assign col_addr     = ADDR_W'(item.column);
	assign cnt_addr     = ADDR_W'(cnt_q);
	assign last_col     = (cnt_q == n_eff - COUNT_W'(1));
	assign slot_free    = !out_valid_q || result.ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= HEIGHT_RESET;
			column_count_q  <= COLUMNS_RESET;
			row_scale_q     <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEIGHT:  screen_height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_COLUMNS: column_count_q  <= cfg_data[COUNT_W-1:0];
				CFG_SCALE:   row_scale_q     <= cfg_data[SCALE_W-1:0];
				default:     ;
			endcase
		end
	end

	// Random walk for seeding: column zero starts it, later columns step and clamp it.
	always_comb begin
		rand_mod3 = mod3_byte(item.rand_value);
		walk_sum  = (WALK_W+1)'(walk_q) + signed'((WALK_W+1)'(rand_mod3)) - (WALK_W+1)'(1);
		if (item.column == '0) begin
			walk_new   = WALK_W'(-signed'({1'b0, item.rand_value[3:0]}));
			seed_value = OFF_W'(walk_new);
		end else begin
			if (walk_sum > 0) begin
				walk_new = '0;
			end else if (int'(walk_sum) <= WALK_FLOOR) begin
				walk_new = WALK_MIN;
			end else begin
				walk_new = walk_sum[WALK_W-1:0];
			end
			seed_value = OFF_W'(walk_new) * signed'(OFF_W'(scale_eff));
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.cmd)
						CMD_TICK: begin
							if (item.tick_count == '0 || n_eff == '0) begin
								state_d = ST_RESP;
							end else begin
								state_d = ST_T_READ;
							end
						end
						CMD_QUERY: state_d = ST_Q_EVAL;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_Q_EVAL: state_d = ST_RESP;
			ST_T_READ: state_d = ST_T_WRITE;
			ST_T_WRITE: begin
				if (last_col && tick_left_q == TICK_W'(1)) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_T_READ;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and memory port control.
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = col_addr;
		ram_wdata = seed_value;
		ram_re    = 1'b0;
		ram_raddr = col_addr;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ram_we   = accept && item.cmd == CMD_SEED && col_in_range;
				ram_re   = accept && item.cmd == CMD_QUERY;
			end
			ST_T_READ: begin
				ram_re    = 1'b1;
				ram_raddr = cnt_addr;
			end
			ST_T_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_addr;
				ram_wdata = step.new_off;
			end
			default: ;
		endcase
	end

	cmw_offset_ram #(
		.DEPTH (MAX_COLUMNS),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// A query beyond the store reads offset zero.
	assign unit_off = (state_q == ST_Q_EVAL && q_oor_q) ? '0 : ram_rdata;

	cmw_step_unit u_unit (
		.offset(unit_off),
		.height(height_eff),
		.scale (scale_eff),
		.row   (row_q),
		.res   (step)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			tick_left_q <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && item.cmd == CMD_SEED && col_in_range) begin
				walk_q <= walk_new;
			end
			if (accept && item.cmd == CMD_TICK) begin
				cnt_q       <= '0;
				tick_left_q <= item.tick_count;
			end else if (state_q == ST_T_WRITE) begin
				if (last_col) begin
					cnt_q       <= '0;
					tick_left_q <= tick_left_q - TICK_W'(1);
				end else begin
					cnt_q <= cnt_q + COUNT_W'(1);
				end
			end
			if (state_q == ST_RESP && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: built while the item is worked on, then moved to the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q          <= item.row;
			q_oor_q        <= !col_in_range;
			res_done_q     <= (item.cmd == CMD_TICK);
			res_from_end_q <= 1'b0;
			res_src_q      <= '0;
		end
		if (state_q == ST_T_WRITE && step.active) begin
			res_done_q <= 1'b0;
		end
		if (state_q == ST_Q_EVAL) begin
			res_from_end_q <= step.from_end;
			res_src_q      <= step.source_row;
		end
		if (state_q == ST_RESP && slot_free) begin
			out_done_q     <= res_done_q;
			out_from_end_q <= res_from_end_q;
			out_src_q      <= res_src_q;
		end
	end

	assign item.ready        = in_ready;
	assign result.valid      = out_valid_q;
	assign result.done_res   = out_done_q;
	assign result.from_end   = out_from_end_q;
	assign result.source_row = out_src_q;

`ifndef NO_ASSERTIONS
	// The column walk never runs past the active columns or after the last tick.
	a_tick_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_T_READ || state_q == ST_T_WRITE) |-> (cnt_q < n_eff && tick_left_q != '0))
		else $error("tick walk outside column or tick range");

	// A write-back always follows the read of the same column.
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_T_WRITE) |-> ($past(state_q) == ST_T_READ && $past(ram_re)))
		else $error("column write-back without a preceding read");

	// An accepted item always starts work.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted item did not start the sequencer");

	// A finished result reaches the output register once the slot is free.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && slot_free) |=> (result.valid && state_q == ST_IDLE))
		else $error("finished result not presented");
`endif

endmodule

[tb/column_melt_wipe_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the column melt wipe block, with its own offset predictor.
module column_melt_wipe_test;
	import cmw_pkg::*;

	localparam int MAX_COLUMNS   = 512;
	localparam int MAX_HEIGHT    = 4096;
	localparam int ROW_TOP       = 4095;
	localparam int HOLD_AT       = 100;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int SEED_BURST    = 4;
	localparam int RUN_LIMIT_NS  = 20_000_000;

	// Code outside the defined commands; the block changes nothing for it but still returns a result.
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	// One result as the block should return it.
	typedef struct packed {
		logic             done_res;
		logic             from_end;
		logic [ROW_W-1:0] source_row;
	} answer_t;

	// Mirror of the column offsets and registers, with the answers still owed by the block.
	class melt_board;
		logic [HEIGHT_W-1:0] height_reg;
		logic [COUNT_W-1:0]  count_reg;
		logic [SCALE_W-1:0]  scale_reg;
		int                  offsets [MAX_COLUMNS];
		int                  walk;
		answer_t             answers_due [$];
		int unsigned         errors;

		function new();
			height_reg = HEIGHT_RESET;
			count_reg  = COLUMNS_RESET;
			scale_reg  = SCALE_RESET;
			walk       = 0;
			errors     = 0;
			foreach (offsets[i]) offsets[i] = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_HEIGHT: height_reg = data[HEIGHT_W-1:0];
				CFG_COLUMNS: count_reg = data[COUNT_W-1:0];
				CFG_SCALE: scale_reg = data[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		// Applies one accepted command and queues the answer it must produce.
		function void note_command(input logic [CMD_W-1:0] cmd, input logic [RAND_W-1:0] rv,
				input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
				input logic [TICK_W-1:0] ticks);
			answer_t a;
			int      scale;
			int      height;
			int      active;
			int      y;
			int      dy;
			int      t;
			int      i;
			a      = '0;
			scale  = (scale_reg == 0) ? 1 : int'(scale_reg);
			height = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
			active = (count_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(count_reg);
			case (cmd)
				CMD_SEED: begin
					// Column zero restarts the walk unscaled; later columns take one clamped step.
					if (col == 0) begin
						walk       = -int'(rv % 8'd16);
						offsets[0] = walk;
					end else begin
						walk += int'(rv % 8'd3) - 1;
						if (walk > 0) begin
							walk = 0;
						end else if (walk < -15) begin
							walk = -15;
						end
						offsets[col] = walk * scale;
					end
				end
				CMD_TICK: begin
					// Delayed columns count up; moving columns fall but never pass the height.
					a.done_res = 1'b1;
					for (t = 0; t < ticks; t++) begin
						for (i = 0; i < active; i++) begin
							if (offsets[i] < 0) begin
								offsets[i]++;
								a.done_res = 1'b0;
							end else if (offsets[i] < height) begin
								dy = ((offsets[i] < 16) ? offsets[i] + 1 : 8) * scale;
								if (offsets[i] + dy >= height) dy = height - offsets[i];
								offsets[i] += dy;
								a.done_res = 1'b0;
							end
						end
					end
				end
				CMD_QUERY: begin
					// Rows above the column's offset show the end screen.
					y = (col < MAX_COLUMNS) ? offsets[col] : 0;
					if (y < 0) y = 0;
					if (int'(row) < y) begin
						a.from_end   = 1'b1;
						a.source_row = row;
					end else begin
						a.source_row = ROW_W'(int'(row) - y);
					end
				end
				default: ;
			endcase
			answers_due.push_back(a);
		endfunction

		function void check_answer(input logic done_res, input logic from_end,
				input logic [ROW_W-1:0] source_row);
			answer_t a;
			if (answers_due.size() == 0) begin
				$error("result transfer with no command waiting: done_res %0d from_end %0d row %0d",
					done_res, from_end, source_row);
				errors++;
				return;
			end
			a = answers_due.pop_front();
			if (done_res !== a.done_res) begin
				$error("done_res: expected %0d, got %0d", a.done_res, done_res);
				errors++;
			end
			if (from_end !== a.from_end) begin
				$error("from_end: expected %0d, got %0d", a.from_end, from_end);
				errors++;
			end
			if (source_row !== a.source_row) begin
				$error("source_row: expected %0d, got %0d", a.source_row, source_row);
				errors++;
			end
		endfunction

		function int pending();
			return answers_due.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    send_steady = 1'b0;

	cmw_in_if  item_ch ();
	cmw_out_if res_ch ();

	melt_board board = new();

	column_melt_wipe #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_ch),
		.result(res_ch)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offers one command after a random gap and notes it once the transfer happens.
	task automatic put_command(input logic [CMD_W-1:0] cmd, input logic [RAND_W-1:0] rv,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
			input logic [TICK_W-1:0] ticks);
		int unsigned gap;
		if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.cmd        <= cmd;
		item_ch.rand_value <= rv;
		item_ch.column     <= col;
		item_ch.row        <= row;
		item_ch.tick_count <= ticks;
		do @(posedge clk); while (!item_ch.ready);
		board.note_command(cmd, rv, col, row, ticks);
	endtask

	// Stops offering and waits until every owed result has been taken.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic set_registers(input int unsigned h, input int unsigned c,
			input int unsigned s);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_HEIGHT;
		cfg_data  <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_index <= CFG_COLUMNS;
		cfg_data  <= CFG_DATA_W'(c);
		@(posedge clk);
		cfg_index <= CFG_SCALE;
		cfg_data  <= CFG_DATA_W'(s);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
		board.write_reg(CFG_COLUMNS, CFG_DATA_W'(c));
		board.write_reg(CFG_SCALE, CFG_DATA_W'(s));
	endtask

	// Seeds columns from zero upward, as a wipe starts.
	task automatic seed_run(input int unsigned len);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			put_command(CMD_SEED, RAND_W'($urandom), COL_W'(i), ROW_W'($urandom),
				TICK_W'($urandom));
		end
	endtask

	// One register setting followed by a seeded wipe and a random mix of commands.
	task automatic run_phase(input int unsigned h, input int unsigned c, input int unsigned s,
			input int unsigned n_items);
		int unsigned      active;
		int unsigned      tick_max;
		int unsigned      row_top;
		int unsigned      pick;
		int unsigned      len;
		int unsigned      issued;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		wait_drained();
		set_registers(h, c, s);
		active   = (c > MAX_COLUMNS) ? MAX_COLUMNS : c;
		// Keep the tick walk short where many columns are active.
		tick_max = (active == 0 || 1024 / active > 15) ? 15 : 1024 / active;
		row_top  = (h > ROW_TOP) ? ROW_TOP : h;
		issued   = 0;
		seed_run((active > SEED_BURST) ? SEED_BURST : active);
		while (issued < n_items) begin
			pick = $urandom_range(0, 99);
			if (active > 0 && $urandom_range(0, 3) != 0) begin
				col = COL_W'($urandom_range(0, active - 1));
			end else begin
				col = COL_W'($urandom_range(0, MAX_COLUMNS - 1));
			end
			if ($urandom_range(0, 1) != 0) begin
				row = ROW_W'($urandom_range(0, row_top));
			end else begin
				row = ROW_W'($urandom_range(0, ROW_TOP));
			end
			if (pick < 45) begin
				put_command(CMD_QUERY, RAND_W'($urandom), col, row, TICK_W'($urandom));
				issued++;
			end else if (pick < 65) begin
				put_command(CMD_TICK, RAND_W'($urandom), col, row,
					TICK_W'($urandom_range(0, tick_max)));
				issued++;
			end else if (pick < 75) begin
				put_command(CMD_SEED, RAND_W'($urandom), col, row, TICK_W'($urandom));
				issued++;
			end else if (pick < 80) begin
				put_command(CMD_NONE, RAND_W'($urandom), col, row, TICK_W'($urandom));
			end else if (pick < 83) begin
				wait_drained();
			end else if (pick < 90 && active > 0) begin
				len = $urandom_range(1, (active > SEED_BURST) ? SEED_BURST : active);
				seed_run(len);
				issued += len;
			end else begin
				put_command(CMD_QUERY, RAND_W'($urandom), col, row, TICK_W'($urandom));
				issued++;
			end
		end
	endtask

	// Takes results after random stalls, with one long hold-off early in the run.
	initial begin : result_sink
		int unsigned stall;
		int unsigned taken;
		bit          steady;
		res_ch.ready = 1'b0;
		taken        = 0;
		steady       = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0) steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 16);
			if (taken == HOLD_AT) stall = HOLD_CYCLES;
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			board.check_answer(res_ch.done_res, res_ch.from_end, res_ch.source_row);
			taken++;
		end
	end

	// Command stream: reset, full seeding, directed cases, then register phases.
	initial begin : command_source
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_HEIGHT;
		cfg_data           = '0;
		item_ch.valid      = 1'b0;
		item_ch.cmd        = CMD_SEED;
		item_ch.rand_value = '0;
		item_ch.column     = '0;
		item_ch.row        = '0;
		item_ch.tick_count = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed the top column first so the walk starts from its reset value, then every column.
		put_command(CMD_SEED, RAND_W'($urandom), COL_W'(MAX_COLUMNS - 1), ROW_W'($urandom),
			TICK_W'($urandom));
		seed_run(MAX_COLUMNS);

		// Unknown command, empty tick and queries at the field extremes.
		put_command(CMD_NONE, 8'd255, 9'd511, 12'd4095, 4'd15);
		put_command(CMD_TICK, 8'd0, 9'd0, 12'd0, 4'd0);
		put_command(CMD_QUERY, 8'd0, 9'd0, 12'd0, 4'd0);
		put_command(CMD_QUERY, 8'd255, 9'd511, 12'd4095, 4'd15);
		// Walk clamped at both ends and a full-depth first column.
		put_command(CMD_SEED, 8'd255, 9'd0, 12'd0, 4'd0);
		put_command(CMD_SEED, 8'd0, 9'd1, 12'd0, 4'd0);
		put_command(CMD_SEED, 8'd2, 9'd2, 12'd0, 4'd0);
		put_command(CMD_SEED, 8'd255, 9'd3, 12'd0, 4'd0);
		put_command(CMD_SEED, 8'd16, 9'd0, 12'd0, 4'd0);
		put_command(CMD_SEED, 8'd2, 9'd1, 12'd0, 4'd0);
		// Melt until every column has reached the bottom.
		put_command(CMD_TICK, 8'd0, 9'd0, 12'd0, 4'd1);
		put_command(CMD_TICK, 8'd0, 9'd0, 12'd0, 4'd15);
		put_command(CMD_QUERY, 8'd0, 9'd1, 12'd0, 4'd0);
		put_command(CMD_QUERY, 8'd0, 9'd1, 12'd4095, 4'd0);
		put_command(CMD_QUERY, 8'd0, 9'd160, 12'd100, 4'd0);
		repeat (4) put_command(CMD_TICK, 8'd0, 9'd0, 12'd0, 4'd15);
		put_command(CMD_QUERY, 8'd0, 9'd159, 12'd199, 4'd0);
		put_command(CMD_QUERY, 8'd0, 9'd0, 12'd200, 4'd0);

		// Register settings that range from the smallest to the saturating ones.
		run_phase(4096, 8, 16, 8);
		run_phase(1, 1, 1, 5);
		run_phase(0, 4, 0, 5);
		run_phase(100, 0, 7, 4);
		run_phase(8191, 1023, 31, 5);
		run_phase(300, 32, 3, 8);
		run_phase(4095, 512, 2, 5);
		run_phase(64, 16, 5, 8);
		run_phase(200, 160, 1, 8);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Ends a run that hangs.
	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
hdl/cmw_pkg.sv
hdl/cmw_if.sv
hdl/cmw_offset_ram.sv
hdl/cmw_step_unit.sv
hdl/column_melt_wipe.sv
tb/column_melt_wipe_test.sv
